### hw/rtl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, codes and helpers of the posting count threshold filter.
// ----------------------------------------------------------------------------
package pcf_pkg;

  // Counter store geometry.
  localparam int ChunkEntries = 65536;
  localparam int AddrW        = $clog2(ChunkEntries);
  localparam int CountW       = 16;
  localparam int IdW          = 16;

  // Field and register widths.
  localparam int SkipW   = 8;
  localparam int MinW    = 8;
  localparam int PrefixW = 10;
  localparam int CombW   = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 10;
  // Widest threshold product, min_overlap * (p-1) * (p-2).
  localparam int ProdW   = MinW + 2 * PrefixW;

  // Item commands.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SKIP_WEIGHT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_OVERLAP = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PREFIX_LEN  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COMB_SIZE   = 2'd3;

  // Combination sizes; a zero code counts as singles.
  typedef enum logic [CombW-1:0] {
    COMB_SINGLE = 2'd1,
    COMB_PAIR   = 2'd2,
    COMB_TRIPLE = 2'd3
  } pcf_comb_e;

  // Settled configuration handed from the register block to the datapath.
  typedef struct packed {
    logic [SkipW-1:0] skip_weight;
    logic [CombW-1:0] comb;
    logic [ProdW-1:0] prod;
    logic             busy;
  } pcf_cfg_t;

  // The threshold is floor(prod / k) with k = 6, 2 or 1. A count c reaches
  // it exactly when prod <= k * c + (k - 1), so no division is needed.
  function automatic logic pcf_passes(logic [CombW-1:0] comb, logic [ProdW-1:0] prod,
                                      logic [CountW-1:0] count);
    logic [ProdW-1:0] c_w;
    logic [ProdW-1:0] lim;
    c_w = {{(ProdW-CountW){1'b0}}, count};
    case (comb)
      COMB_TRIPLE: lim = (c_w << 2) + (c_w << 1) + ProdW'(5);
      COMB_PAIR:   lim = (c_w << 1) + ProdW'(1);
      default:     lim = c_w;
    endcase
    return prod <= lim;
  endfunction

endpackage

### hw/rtl/pcf_count_store.sv
// ----------------------------------------------------------------------------
// pcf_count_store
// Hit counter memory with registered read and a clearing sweep.
// ----------------------------------------------------------------------------
module pcf_count_store import pcf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [CountW-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [CountW-1:0] wr_data_i,
  output logic              clearing_o
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(ChunkEntries - 1);

  logic [CountW-1:0] mem [ChunkEntries];
  logic              clr_q, clr_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic              we;
  logic [AddrW-1:0]  wa;
  logic [CountW-1:0] wd;

  // The sweep walks every entry once after reset, writing zero.
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The sweep owns the write port while it runs.
  assign we = clr_q | wr_en_i;
  assign wa = clr_q ? clr_addr_q : wr_addr_i;
  assign wd = clr_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Registered read; a write in the same cycle is not seen.
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

  assign clearing_o = clr_q;

endmodule

### hw/rtl/pcf_threshold.sv
// ----------------------------------------------------------------------------
// pcf_threshold
// Configuration registers and the two-stage threshold product.
// ----------------------------------------------------------------------------
module pcf_threshold import pcf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output pcf_cfg_t           cfg_o
);

  logic [SkipW-1:0]   skip_q;
  logic [MinW-1:0]    min_q;
  logic [PrefixW-1:0] prefix_q;
  logic [CombW-1:0]   comb_q;
  logic [PrefixW-1:0] p1, p2;
  logic [MinW+PrefixW-1:0] mp1_q;
  logic [PrefixW-1:0] p2_q;
  logic [MinW-1:0]    min_a_q;
  logic [CombW-1:0]   comb_a_q, comb_b_q;
  logic [ProdW-1:0]   prod_q;
  logic [1:0]         settle_q, settle_d;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   <= SkipW'(1);
      min_q    <= MinW'(2);
      prefix_q <= PrefixW'(32);
      comb_q   <= COMB_SINGLE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SKIP_WEIGHT: skip_q   <= cfg_wdata_i[SkipW-1:0];
        CFG_MIN_OVERLAP: min_q    <= cfg_wdata_i[MinW-1:0];
        CFG_PREFIX_LEN:  prefix_q <= cfg_wdata_i[PrefixW-1:0];
        CFG_COMB_SIZE:   comb_q   <= cfg_wdata_i[CombW-1:0];
        default:         ;
      endcase
    end
  end

  // p-1 and p-2 stop at zero for short prefixes.
  assign p1 = (prefix_q >= PrefixW'(1)) ? prefix_q - PrefixW'(1) : '0;
  assign p2 = (prefix_q >= PrefixW'(2)) ? prefix_q - PrefixW'(2) : '0;

  // First stage: m * (p-1).
  always_ff @(posedge clk_i) begin
    mp1_q    <= {{PrefixW{1'b0}}, min_q} * {{MinW{1'b0}}, p1};
    p2_q     <= p2;
    min_a_q  <= min_q;
    comb_a_q <= comb_q;
  end

  // Second stage: pick the product that the combination size asks for.
  always_ff @(posedge clk_i) begin
    comb_b_q <= comb_a_q;
    case (comb_a_q)
      COMB_TRIPLE: prod_q <= {{PrefixW{1'b0}}, mp1_q} * {{(MinW+PrefixW){1'b0}}, p2_q};
      COMB_PAIR:   prod_q <= {{PrefixW{1'b0}}, mp1_q};
      default:     prod_q <= {{(2*PrefixW){1'b0}}, min_a_q};
    endcase
  end

  // Hold the input side off until a new setting has passed both stages.
  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = 2'd2;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'd2;
    end else begin
      settle_q <= settle_d;
    end
  end

  assign cfg_o.skip_weight = skip_q;
  assign cfg_o.comb        = comb_b_q;
  assign cfg_o.prod        = prod_q;
  assign cfg_o.busy        = (settle_q != 2'd0);

endmodule

### hw/rtl/posting_count_threshold_filter.sv
// ----------------------------------------------------------------------------
// posting_count_threshold_filter
// Inverted index candidate filter: per-document hit counters and test.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle in steady state: each beat reads
// its counter from the single counter RAM in the cycle it is accepted and
// writes it back when it leaves stage one, with the last write forwarded so
// that back-to-back beats on the same document see each other. A test beat
// puts its result beat in an output register as it leaves stage one. Besides
// the sweep and configuration writes, the input stalls only while a test beat
// in stage one waits on a result in that register that is not being taken.
// After reset the counter RAM is swept to zero, one entry a cycle, over all
// ChunkEntries (65536) entries before the first beat is taken. A config write
// holds the input off while the threshold product settles.
module posting_count_threshold_filter import pcf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_cmd_i,
  input  logic [IdW-1:0]     in_doc_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IdW-1:0]     out_result_id_o,
  output logic               out_passes_o,
  output logic [CountW-1:0]  out_hit_count_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  pcf_cfg_t          cfg;
  logic              clearing;
  logic              accept;
  logic              s1_valid_q;
  logic              s1_cmd_q;
  logic [IdW-1:0]    s1_id_q;
  logic              s1_adv, s1_fire, s1_in_chunk;
  logic [AddrW-1:0]  rd_addr;
  logic [CountW-1:0] rd_data, cur;
  logic [CountW:0]   sum;
  logic              wr_en;
  logic [CountW-1:0] wr_data;
  logic              fwd_valid_q;
  logic [AddrW-1:0]  fwd_addr_q;
  logic [CountW-1:0] fwd_data_q;
  logic              out_valid_q;
  logic [IdW-1:0]    out_id_q;
  logic              out_pass_q;
  logic [CountW-1:0] out_count_q;
  logic [CountW-1:0] test_count;

  pcf_threshold u_thr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Stage one can retire unless it holds a test and the output is occupied and not being taken.
  assign s1_adv     = (s1_cmd_q == CMD_ADD) | ~out_valid_q | out_ready_i;
  assign s1_fire    = s1_valid_q & s1_adv;
  assign in_ready_o = ~clearing & ~cfg.busy & (~s1_valid_q | s1_adv);
  assign accept     = in_valid_i & in_ready_o;

  // A stalled beat reads its own entry again so the read data stays current.
  assign rd_addr = accept ? in_doc_id_i[AddrW-1:0] : s1_id_q[AddrW-1:0];

  pcf_count_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_id_q[AddrW-1:0]),
    .wr_data_i (wr_data),
    .clearing_o(clearing)
  );

  // Stage one register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= in_cmd_i;
      s1_id_q  <= in_doc_id_i;
    end
  end

  // Modify: take the forwarded value if last cycle wrote this entry.
  assign s1_in_chunk = 32'(s1_id_q) < ChunkEntries;
  assign cur = (fwd_valid_q && fwd_addr_q == s1_id_q[AddrW-1:0]) ? fwd_data_q : rd_data;
  assign sum = {1'b0, cur} + {{(CountW+1-SkipW){1'b0}}, cfg.skip_weight};

  always_comb begin
    if (s1_cmd_q == CMD_ADD) begin
      wr_data = sum[CountW] ? '1 : sum[CountW-1:0];
    end else begin
      wr_data = '0;
    end
  end

  assign wr_en      = s1_fire & s1_in_chunk;
  assign test_count = s1_in_chunk ? cur : '0;

  // Forwarding register: the write made in the previous cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_id_q[AddrW-1:0];
      fwd_data_q <= wr_data;
    end
  end

  // Output register for result beats.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_cmd_q == CMD_TEST) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_cmd_q == CMD_TEST) begin
      out_id_q    <= s1_id_q;
      out_count_q <= test_count;
      out_pass_q  <= pcf_passes(cfg.comb, cfg.prod, test_count);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_result_id_o = out_id_q;
  assign out_passes_o    = out_pass_q;
  assign out_hit_count_o = out_count_q;

endmodule

### hw/rtl/pcf_checker.sv
// ----------------------------------------------------------------------------
// pcf_checker
// Port-level checks of the posting count threshold filter, bound to the top.
// ----------------------------------------------------------------------------
module pcf_checker import pcf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               in_cmd_i,
  input logic [IdW-1:0]     in_doc_id_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [IdW-1:0]     out_result_id_o,
  input logic               out_passes_o,
  input logic [CountW-1:0]  out_hit_count_o,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [CfgW-1:0]    cfg_wdata_i
);

  // A result beat held back keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_result_id_o) &&
      $stable(out_passes_o) && $stable(out_hit_count_o))
    else $error("result beat dropped or changed while stalled");

  // A fresh result beat comes only from an accepted test beat: the beat passes
  // through the read stage, then lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_cmd_i == CMD_TEST, 2))
    else $error("result beat without a preceding test beat");

  // The clearing sweep keeps the input closed straight after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("input open during the clearing sweep");

  // A register write holds the input off while the threshold settles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o ##1 !in_ready_o)
    else $error("input open before the threshold settled");

endmodule

bind posting_count_threshold_filter pcf_checker u_pcf_checker (.*);

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the posting count threshold filter. A scoreboard
// keeps its own copy of the hit counters and registers, predicts the result
// of every accepted test beat and checks each result beat against the oldest
// prediction. Directed beats cover the field extremes and corner cases, and
// random phases follow under changing register settings and handshake idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pcf_pkg::*;

  // Comb size code that has no enum member; the block treats it as singles.
  localparam logic [CombW-1:0] CombZero = '0;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 115;

  // One predicted result beat.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic              passes;
    logic [CountW-1:0] count;
  } verdict_t;

  // Predictor of the filter and store of the verdicts still awaited.
  class pcf_scoreboard;
    logic [CountW-1:0]  counts [ChunkEntries];
    logic [SkipW-1:0]   skip_weight;
    logic [MinW-1:0]    min_overlap;
    logic [PrefixW-1:0] prefix_len;
    logic [CombW-1:0]   comb_size;
    verdict_t           verdicts [$];
    int                 mismatches;

    function new();
      foreach (counts[i]) counts[i] = '0;
      skip_weight = 8'd1;
      min_overlap = 8'd2;
      prefix_len  = 10'd32;
      comb_size   = COMB_SINGLE;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CFG_SKIP_WEIGHT: skip_weight = val[SkipW-1:0];
        CFG_MIN_OVERLAP: min_overlap = val[MinW-1:0];
        CFG_PREFIX_LEN:  prefix_len  = val[PrefixW-1:0];
        CFG_COMB_SIZE:   comb_size   = val[CombW-1:0];
        default: ;
      endcase
    endfunction

    // Required count; the prefix terms stop at zero for short prefixes.
    function longint unsigned required_hits();
      longint unsigned m;
      longint unsigned p1;
      longint unsigned p2;
      m  = min_overlap;
      p1 = (prefix_len >= 1) ? prefix_len - 1 : 0;
      p2 = (prefix_len >= 2) ? prefix_len - 2 : 0;
      if (comb_size == COMB_TRIPLE) return m * p1 * p2 / 6;
      if (comb_size == COMB_PAIR) return m * p1 / 2;
      return m;
    endfunction

    // An add raises the counter with saturation; a test reads and clears it.
    function void note_item(logic cmd, logic [IdW-1:0] id);
      int unsigned sum;
      verdict_t    v;
      if (cmd == CMD_ADD) begin
        if (int'(id) < ChunkEntries) begin
          sum = counts[id] + skip_weight;
          if (sum > 65535) sum = 65535;
          counts[id] = sum[CountW-1:0];
        end
      end else begin
        v.id    = id;
        v.count = '0;
        if (int'(id) < ChunkEntries) begin
          v.count    = counts[id];
          counts[id] = '0;
        end
        v.passes = (longint'(v.count) >= required_hits());
        verdicts = {verdicts, v};
      end
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [IdW-1:0] id, logic passes, logic [CountW-1:0] count);
      verdict_t v;
      if (verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat id %0d with nothing awaited", id));
      end else begin
        v = verdicts.pop_front();
        if (id !== v.id)
          report_mismatch($sformatf("result_id %0d, awaited %0d", id, v.id));
        if (passes !== v.passes)
          report_mismatch($sformatf("passes %0b, awaited %0b for id %0d",
                                    passes, v.passes, v.id));
        if (count !== v.count)
          report_mismatch($sformatf("hit_count %0d, awaited %0d for id %0d",
                                    count, v.count, v.id));
      end
    endtask

    task check_drained();
      if (verdicts.size() != 0)
        report_mismatch($sformatf("%0d result beats never arrived", verdicts.size()));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               in_cmd_i = CMD_ADD;
  logic [IdW-1:0]     in_doc_id_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [IdW-1:0]     out_result_id_o;
  logic               out_passes_o;
  logic [CountW-1:0]  out_hit_count_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_wdata_i = '0;

  pcf_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  posting_count_threshold_filter DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_cmd_i,
    .in_doc_id_i,
    .out_valid_o,
    .out_ready_i,
    .out_result_id_o,
    .out_passes_o,
    .out_hit_count_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver ready: random idling, or a long hold-off when one is asked for.
  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result beats are checked at the edge that takes them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i)
      sb.check_result(out_result_id_o, out_passes_o, out_hit_count_o);
  end

  // Offer one input beat, idling first at random; returns at a falling edge.
  task send_item(input logic cmd, input logic [IdW-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_cmd_i    <= cmd;
    in_doc_id_i <= id;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_item(cmd, id);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every awaited result, then let any add beat
  // still in the pipeline finish.
  task drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Idle the block, then write all four registers.
  task apply_config(input int skip, input int min_ov, input int prefix, input int comb);
    drain();
    write_reg(CFG_SKIP_WEIGHT, CfgW'(skip));
    write_reg(CFG_MIN_OVERLAP, CfgW'(min_ov));
    write_reg(CFG_PREFIX_LEN, CfgW'(prefix));
    write_reg(CFG_COMB_SIZE, CfgW'(comb));
    cfg_we_i <= 1'b0;
  endtask

  // One random phase: a fresh setting, a pool of hot documents so that
  // counts build up, and occasional ids from the whole range.
  task random_phase(input int phase);
    logic [IdW-1:0] pool [8];
    int skip;
    int min_ov;
    int prefix;
    int test_pct;
    logic cmd;
    logic [IdW-1:0] id;
    case ($urandom_range(4))
      0: skip = 0;
      1: skip = 1;
      2: skip = 255;
      default: skip = $urandom_range(1, 255);
    endcase
    case ($urandom_range(3))
      0: min_ov = 0;
      1: min_ov = 255;
      default: min_ov = $urandom_range(1, 64);
    endcase
    case ($urandom_range(5))
      0: prefix = 0;
      1: prefix = 1;
      2: prefix = 2;
      3: prefix = 512;
      4: prefix = $urandom_range(1, 512);
      default: prefix = $urandom_range(3, 12);
    endcase
    apply_config(skip, min_ov, prefix, $urandom_range(3));
    foreach (pool[i]) pool[i] = IdW'($urandom_range(65535));
    test_pct = $urandom_range(8, 30);
    for (int n = 0; n < PhaseItems; n++) begin
      // Long receiver hold-off while beats keep coming.
      if ((phase == 2 || phase == 8) && n == 40) hold_asks++;
      // Sender pause until all results are in.
      if (phase == 5 && n == 60) begin
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
      end
      cmd = ($urandom_range(99) < test_pct) ? CMD_TEST : CMD_ADD;
      id  = ($urandom_range(99) < 85) ? pool[$urandom_range(7)] : IdW'($urandom_range(65535));
      send_item(cmd, id);
    end
  endtask

  // Watchdog.
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 21;
    recv_idle_pct = 62;

    // Reset settings; the first beat waits out the counter sweep.
    send_item(CMD_ADD, 16'd0);
    send_item(CMD_ADD, 16'd0);
    send_item(CMD_TEST, 16'd0);
    send_item(CMD_ADD, 16'hFFFF);
    send_item(CMD_TEST, 16'hFFFF);
    send_item(CMD_TEST, 16'hFFFF);
    send_item(CMD_TEST, 16'h5A5A);

    // Zero skip weight with a zero threshold.
    apply_config(0, 0, 1, COMB_PAIR);
    send_item(CMD_ADD, 16'd3);
    send_item(CMD_TEST, 16'd3);

    // Comb size zero counts as singles; zero prefix.
    apply_config(255, 255, 0, CombZero);
    send_item(CMD_ADD, 16'd7);
    send_item(CMD_ADD, 16'd7);
    send_item(CMD_TEST, 16'd7);
    send_item(CMD_TEST, 16'd8);

    // Threshold beyond the counter range, then a two-pivot prefix for triples.
    apply_config(255, 255, 512, COMB_TRIPLE);
    send_item(CMD_ADD, 16'd9);
    send_item(CMD_TEST, 16'd9);
    apply_config(17, 200, 2, COMB_TRIPLE);
    send_item(CMD_ADD, 16'd10);
    send_item(CMD_TEST, 16'd10);

    // Pairs: a threshold of 20 reached exactly, and one missed.
    apply_config(10, 5, 9, COMB_PAIR);
    send_item(CMD_ADD, 16'd11);
    send_item(CMD_ADD, 16'd11);
    send_item(CMD_TEST, 16'd11);
    send_item(CMD_ADD, 16'd12);
    send_item(CMD_TEST, 16'd12);

    // Random phases under the three idling regimes.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 62;
        recv_idle_pct = 21;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase(ph);
    end

    // Saturation: a long run of heavy adds on one document.
    apply_config(255, 255, 1, COMB_SINGLE);
    for (int n = 0; n < 300; n++) send_item(CMD_ADD, 16'hBEEF);
    send_item(CMD_TEST, 16'hBEEF);
    send_item(CMD_TEST, 16'hBEEF);

    drain();
    repeat (10) @(posedge clk_i);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_count_store.sv
hw/rtl/pcf_threshold.sv
hw/rtl/posting_count_threshold_filter.sv
hw/rtl/pcf_checker.sv
test/testbench.sv
